### rtl/bra_pkg.sv
`default_nettype none
package bra_pkg;

    localparam int MAX_BITS  = 4096;
    localparam int WORD_BITS = 32;
    localparam int WIDX_W    = 5;

    // Request codes.
    localparam logic [1:0] REQ_ALLOC   = 2'd0;
    localparam logic [1:0] REQ_RELEASE = 2'd1;
    localparam logic [1:0] REQ_RESERVE = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [11:0] start_index;
        logic [12:0] run_length;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] run_start;
    } t_rsp;

endpackage
`default_nettype wire

### rtl/bitmap_run_allocator.sv
// Rejected and zero-length requests go from idle to the result state, which posts the result;
// release/reserve read and then write each 32-bit word touched before the result state.
// Allocate scans 1 bit per cycle, pausing in a read state for each word entered, then sets
// the run back with a read and a write per word and posts the result from the result state.
// Throughput: one request at a time; the next transfer waits until the result has left.
// Reset (synchronous, active low) then clears 1 word per cycle over all 128 words; bitmap_bits = 4096.
`default_nettype none
module bitmap_run_allocator (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_cfg_valid,
    output logic          o_cfg_ready,
    input  wire  [12:0]   i_cfg_data,
    input  wire           i_req_valid,
    output logic          o_req_stall,
    input  bra_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  wire           i_rsp_stall,
    output bra_pkg::t_rsp o_rsp
);
    import bra_pkg::*;

    localparam int NWORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int BW     = AW + WIDX_W;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_SCAN_RD, S_SCAN, S_WR_RD, S_WR, S_RESP
    } t_state;

    t_state      r_state;
    logic [12:0] r_size;
    logic [13:0] r_pos;     // bit under scan, or next bit to write
    logic [13:0] r_end;     // bit beyond the last one
    logic [13:0] r_first;
    logic [12:0] r_run;
    logic [12:0] r_len;
    logic [13:0] r_lim;     // scan limit: effective size
    logic        r_val;     // value written to the range
    logic [AW-1:0] r_clr;
    logic        r_rsp_v;
    t_rsp        r_rsp;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [31:0]   ram_wdata, ram_rdata;

    bra_ram #(.WIDTH(WORD_BITS), .DEPTH(NWORDS)) u_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_waddr), .i_wdata(ram_wdata),
        .i_raddr(ram_raddr), .o_rdata(ram_rdata)
    );

    // Effective size clamps to the memory.
    logic [13:0] eff_size;
    assign eff_size = ({1'b0, r_size} > 14'(MAX_BITS)) ? 14'(MAX_BITS) : {1'b0, r_size};

    // Word mask of the range bits inside the word at r_pos.
    logic [31:0] wmask;
    logic [13:0] wbase;
    always_comb begin
        wbase = {r_pos[13:WIDX_W], {WIDX_W{1'b0}}};
        for (int b = 0; b < WORD_BITS; b++) begin
            wmask[b] = ((wbase + 14'(b)) >= r_pos) && ((wbase + 14'(b)) < r_end);
        end
    end

    logic        cur_bit;
    assign cur_bit = ram_rdata[r_pos[WIDX_W-1:0]];

    logic [AW-1:0] pos_word;
    assign pos_word = AW'(r_pos[13:WIDX_W]);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = pos_word;
        ram_wdata = r_val ? (ram_rdata | wmask) : (ram_rdata & ~wmask);
        ram_raddr = pos_word;
        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
            end
            S_WR:    ram_we = 1'b1;
            default: ram_we = 1'b0;
        endcase
    end

    assign o_cfg_ready = 1'b1;
    assign o_req_stall = (r_state != S_IDLE) || r_rsp_v;
    assign o_rsp_valid = r_rsp_v;
    assign o_rsp       = r_rsp;

    logic [13:0] req_end;
    assign req_end = {2'b0, i_req.start_index} + {1'b0, i_req.run_length};

    // Control sequencer with registered result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_size  <= 13'd4096;
            r_clr   <= '0;
            r_rsp_v <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_size <= i_cfg_data;
            end
            if (r_rsp_v && !i_rsp_stall) begin
                r_rsp_v <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(NWORDS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_req_valid && !r_rsp_v) begin
                        r_len         <= i_req.run_length;
                        r_pos         <= {2'b0, i_req.start_index};
                        r_lim         <= eff_size;
                        r_run         <= '0;
                        r_rsp.run_start <= '0;
                        if (i_req.req_type == REQ_ALLOC) begin
                            r_val <= 1'b1;
                            if (i_req.run_length == '0 ||
                                {1'b0, i_req.run_length} > eff_size) begin
                                r_rsp.status <= ST_INVALID;
                                r_state      <= S_RESP;
                            end else if ({2'b0, i_req.start_index} >= eff_size) begin
                                r_rsp.status <= ST_NOFIT;
                                r_state      <= S_RESP;
                            end else begin
                                r_state <= S_SCAN_RD;
                            end
                        end else if (i_req.req_type == REQ_RELEASE ||
                                     i_req.req_type == REQ_RESERVE) begin
                            r_val <= (i_req.req_type == REQ_RESERVE);
                            r_end <= req_end;
                            if (req_end > eff_size) begin
                                r_rsp.status <= ST_INVALID;
                                r_state      <= S_RESP;
                            end else if (i_req.run_length == '0) begin
                                r_rsp.status <= ST_DONE;
                                r_state      <= S_RESP;
                            end else begin
                                r_rsp.status <= ST_DONE;
                                r_state      <= S_WR_RD;
                            end
                        end else begin
                            r_rsp.status <= ST_INVALID;
                            r_state      <= S_RESP;
                        end
                    end
                end
                S_SCAN_RD: r_state <= S_SCAN;
                S_SCAN: begin
                    // One bit per cycle; reread when crossing into the next word.
                    if (!cur_bit) begin
                        if (r_run == '0) begin
                            r_first <= r_pos;
                        end
                        if (r_run + 13'd1 == r_len) begin
                            r_rsp.status    <= ST_DONE;
                            r_rsp.run_start <= (r_run == '0) ? r_pos[11:0] : r_first[11:0];
                            r_pos   <= (r_run == '0) ? r_pos : r_first;
                            r_end   <= r_pos + 14'd1;
                            r_state <= S_WR_RD;
                        end else begin
                            r_run <= r_run + 13'd1;
                        end
                    end else begin
                        r_run <= '0;
                    end
                    if (!(!cur_bit && r_run + 13'd1 == r_len)) begin
                        if (r_pos + 14'd1 >= r_lim) begin
                            r_rsp.status <= ST_NOFIT;
                            r_state      <= S_RESP;
                        end else begin
                            r_pos <= r_pos + 14'd1;
                            if (r_pos[WIDX_W-1:0] == '1) begin
                                r_state <= S_SCAN_RD;
                            end
                        end
                    end
                end
                S_WR_RD: r_state <= S_WR;
                S_WR: begin
                    // Read-modify-write one word, then step to the next.
                    if (wbase + 14'(WORD_BITS) >= r_end) begin
                        r_state <= S_RESP;
                    end else begin
                        r_pos   <= wbase + 14'(WORD_BITS);
                        r_state <= S_WR_RD;
                    end
                end
                S_RESP: begin
                    r_rsp_v <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // A result waits only while the sequencer is idle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rsp_v |-> (r_state == S_IDLE || r_state == S_CLEAR))
        else $error("result pending while busy");
    // Writes happen only in the sweep or write state.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_CLEAR || r_state == S_WR))
        else $error("stray memory write");
    // The write state comes in the cycle after its read state.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR) |-> $past(r_state == S_WR_RD))
        else $error("write without read");
endmodule
`default_nettype wire

### rtl/bra_ram.sv
`default_nettype none
module bra_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### sim/tb_bitmap_run_allocator.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_bitmap_run_allocator;
    import bra_pkg::*;

    localparam int NWORDS    = 128;
    localparam int MAXB      = 4096;
    localparam int IDLE_WAIT = 12000;
    localparam int WD_LIMIT  = 60000;

    // Request code with no defined meaning.
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    logic          clk;
    logic          rst_n;
    logic          cfg_valid;
    logic          cfg_ready;
    logic [12:0]   cfg_data;
    logic          req_valid;
    logic          req_stall;
    t_req          req;
    logic          rsp_valid;
    logic          rsp_stall;
    t_rsp          rsp;

    // Mirror of the allocator state.
    logic [31:0]   shadow_map [NWORDS];
    logic [12:0]   shadow_size;
    t_rsp          pending_rsp [$];
    int            err_cnt;
    int            idle_cycles;
    int            stall_left;

    bitmap_run_allocator DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data),
        .i_req_valid(req_valid),
        .o_req_stall(req_stall),
        .i_req      (req),
        .o_rsp_valid(rsp_valid),
        .i_rsp_stall(rsp_stall),
        .o_rsp      (rsp)
    );

    always #5 clk = ~clk;

    function automatic bit map_bit(int i);
        return shadow_map[(i / 32) % NWORDS][i % 32];
    endfunction

    function automatic void map_fill(int first, int count, bit value);
        int i;
        for (i = first; i < first + count; i++) begin
            shadow_map[(i / 32) % NWORDS][i % 32] = value;
        end
    endfunction

    // Compute the result of one request and update the mirror.
    function automatic t_rsp predict_request(t_req r);
        t_rsp o;
        int   size;
        int   run;
        int   first;
        int   i;
        size = (shadow_size > MAXB) ? MAXB : shadow_size;
        o.status = ST_INVALID;
        o.run_start = '0;
        run = 0;
        first = 0;
        if (r.req_type == REQ_ALLOC) begin
            if (r.run_length != 0 && r.run_length <= size) begin
                o.status = ST_NOFIT;
                for (i = r.start_index; i < size; i++) begin
                    if (!map_bit(i)) begin
                        if (run == 0) first = i;
                        run++;
                        if (run == r.run_length) begin
                            map_fill(first, run, 1'b1);
                            o.status = ST_DONE;
                            o.run_start = first[11:0];
                            break;
                        end
                    end else begin
                        run = 0;
                    end
                end
            end
        end else if (r.req_type == REQ_RELEASE || r.req_type == REQ_RESERVE) begin
            if (int'(r.start_index) + int'(r.run_length) <= size) begin
                map_fill(r.start_index, r.run_length, r.req_type == REQ_RESERVE);
                o.status = ST_DONE;
            end
        end
        return o;
    endfunction

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
                                          : $urandom_range(0, 2);
    endfunction

    // Send one request and record its expected result. Valid stays high after the
    // transfer only when the next request follows with no gap.
    task automatic send_request(logic [1:0] kind, int first, int count);
        int g;
        g = gap_len();
        if (g != 0) begin
            req_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        req_valid <= 1'b1;
        req.req_type <= kind;
        req.start_index <= first[11:0];
        req.run_length <= count[12:0];
        @(posedge clk);
        while (req_stall) @(posedge clk);
        pending_rsp.push_back(predict_request('{kind, first[11:0], count[12:0]}));
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // Write the size register while the allocator is idle.
    task automatic set_size(int value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= value[12:0];
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        shadow_size = value[12:0];
    endtask

    task automatic test_edge_cases();
        send_request(REQ_ALLOC, 0, 0);
        send_request(REQ_ALLOC, 0, 4097);
        send_request(REQ_ALLOC, 0, 8191);
        send_request(REQ_ALLOC, 0, 40);
        send_request(REQ_ALLOC, 5, 1);
        send_request(REQ_ALLOC, 0, 4096 - 41);
        send_request(REQ_ALLOC, 0, 4096);
        send_request(REQ_RELEASE, 0, 4096);
        send_request(REQ_ALLOC, 4095, 1);
        send_request(REQ_ALLOC, 0, 4096);
        send_request(REQ_RELEASE, 4095, 2);
        send_request(REQ_RELEASE, 100, 0);
        send_request(REQ_RESERVE, 31, 34);
        send_request(REQ_UNKNOWN, 7, 5);
        send_request(REQ_RELEASE, 0, 4096);
    endtask

    task automatic test_small_sizes();
        set_size(1);
        send_request(REQ_ALLOC, 0, 1);
        send_request(REQ_ALLOC, 0, 1);
        send_request(REQ_ALLOC, 1, 1);
        send_request(REQ_RELEASE, 0, 1);
        set_size(0);
        send_request(REQ_ALLOC, 0, 1);
        send_request(REQ_RESERVE, 0, 0);
        set_size(8191);
        send_request(REQ_ALLOC, 4000, 96);
        send_request(REQ_RELEASE, 0, 4096);
    endtask

    // Random phases: mostly short runs over shrinking and growing sizes.
    task automatic test_random_traffic();
        int p;
        int n;
        int size;
        int first;
        int count;
        int kind;
        for (p = 0; p < 6; p++) begin
            case (p)
                0: size = 4096;
                1: size = 256;
                2: size = $urandom_range(33, 700);
                3: size = 64;
                4: size = 8191;
                default: size = 4096;
            endcase
            set_size(size);
            if (size > MAXB) size = MAXB;
            for (n = 0; n < 185; n++) begin
                kind = $urandom_range(0, 19);
                first = (size > 1 && $urandom_range(0, 3) != 0) ?
                        $urandom_range(0, size - 1) : $urandom_range(0, 4095);
                if ($urandom_range(0, 29) == 0) count = $urandom_range(0, 8191);
                else if ($urandom_range(0, 3) == 0) count = $urandom_range(0, size);
                else count = $urandom_range(0, 40);
                if (kind < 10) begin
                    if ($urandom_range(0, 2) == 0) first = 0;
                    send_request(REQ_ALLOC, first, count);
                end else if (kind < 16) begin
                    send_request(REQ_RELEASE, first, count);
                end else if (kind < 19) begin
                    send_request(REQ_RESERVE, first, count);
                end else begin
                    send_request(REQ_UNKNOWN, first, count);
                end
            end
        end
    endtask

    // Check each response transfer against the oldest expectation.
    always @(posedge clk) begin
        t_rsp e;
        if (rst_n && rsp_valid && !rsp_stall) begin
            if (pending_rsp.size() == 0) begin
                $error("unexpected response status=%0d run_start=%0d",
                       rsp.status, rsp.run_start);
                err_cnt++;
            end else begin
                e = pending_rsp.pop_front();
                if (rsp.status !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, rsp.status);
                    err_cnt++;
                end
                if (rsp.run_start !== e.run_start) begin
                    $error("run_start: expected %0d, got %0d", e.run_start, rsp.run_start);
                    err_cnt++;
                end
            end
        end
    end

    // Receiver stalls of random length, mostly short and a few long.
    always @(posedge clk) begin
        if (stall_left > 0) begin
            rsp_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            rsp_stall  <= 1'b1;
            stall_left <= gap_len();
        end else begin
            rsp_stall <= 1'b0;
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk) begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
            (cfg_valid && cfg_ready) || !rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WD_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int i;
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        req_valid = 1'b0;
        req = '0;
        rsp_stall = 1'b0;
        err_cnt = 0;
        idle_cycles = 0;
        shadow_size = 13'd4096;
        for (i = 0; i < NWORDS; i++) shadow_map[i] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_edge_cases();
        test_small_sizes();
        test_random_traffic();
        drain();
        repeat (IDLE_WAIT / 100) @(posedge clk);
        if (err_cnt == 0 && pending_rsp.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

### files.f
rtl/bra_pkg.sv
rtl/bra_ram.sv
rtl/bitmap_run_allocator.sv
sim/tb_bitmap_run_allocator.sv
